### sv/mlft_pkg.sv
package mlft_pkg;

  localparam int TABLE_ENTRIES = 1024;
  localparam int ADDR_W = $clog2(TABLE_ENTRIES);
  localparam int COUNT_W = $clog2(TABLE_ENTRIES + 1);
  localparam int MAC_W = 48;
  localparam int ENTRY_W = MAC_W + 1;

  typedef logic [MAC_W-1:0] mac_t;
  typedef logic [ADDR_W-1:0] addr_t;
  typedef logic [COUNT_W-1:0] count_t;

  typedef enum logic [1:0] {
    LEARN_NEW     = 2'd0,
    LEARN_UPDATED = 2'd1,
    LEARN_FULL    = 2'd2
  } learn_t;

  typedef struct packed {
    logic  src_hit;
    addr_t src_idx;
    logic  dst_hit;
    logic  dst_port;
  } match_t;

endpackage

### sv/mlft_in_if.sv
interface mlft_in_if import mlft_pkg::*; ();
  logic valid;
  logic ready;
  logic ingress_port;
  mac_t source_mac;
  mac_t dest_mac;

  modport source (output valid, output ingress_port, output source_mac, output dest_mac,
                  input ready);
  modport sink (input valid, input ingress_port, input source_mac, input dest_mac,
                output ready);
endinterface

### sv/mlft_out_if.sv
interface mlft_out_if ();
  logic       valid;
  logic       ready;
  logic       egress_port;
  logic       dest_found;
  logic [1:0] learn_status;

  modport source (output valid, output egress_port, output dest_found,
                  output learn_status, input ready);
  modport sink (input valid, input egress_port, input dest_found, input learn_status,
                output ready);
endinterface

### sv/mlft_ram.sv
module mlft_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### sv/mlft_match.sv
module mlft_match import mlft_pkg::*; (
  input  logic                 clk,
  input  logic                 clear,
  input  logic                 valid,
  input  addr_t                idx,
  input  logic [ENTRY_W-1:0]   entry,
  input  mac_t                 src_mac,
  input  mac_t                 dst_mac,
  output match_t               match
);

  mac_t entry_mac;
  logic entry_port;

  assign entry_mac = entry[ENTRY_W-1:1];
  assign entry_port = entry[0];

  always_ff @(posedge clk) begin
    if (clear) begin
      match.src_hit <= 1'b0;
      match.dst_hit <= 1'b0;
    end else if (valid) begin
      if (entry_mac == src_mac) begin
        match.src_hit <= 1'b1;
        match.src_idx <= idx;
      end
      if (entry_mac == dst_mac) begin
        match.dst_hit <= 1'b1;
        match.dst_port <= entry_port;
      end
    end
  end

endmodule

### sv/mac_learning_forward_table.sv
// an accepted item is looked up by a scan of the used entries, then learned, then
// shown as the result; the scan reads one table entry per cycle
// the next item waits until the result has been taken and the block is idle again
// reset: synchronous; the fill count goes to zero, so the table reads empty at once
module mac_learning_forward_table import mlft_pkg::*; (
  input logic            clk,
  input logic            rst,
  mlft_in_if.sink        frame,
  mlft_out_if.source     fwd
);

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_SCAN  = 4'b0010,
    S_WRITE = 4'b0100,
    S_DONE  = 4'b1000
  } state_t;

  state_t state;
  count_t used_entries;
  count_t scan_addr;
  logic   pend;
  addr_t  pend_idx;
  logic   port;
  mac_t   src;
  mac_t   dst;
  logic   rd_en;
  logic   wr_en;
  addr_t  wr_addr;
  logic [ENTRY_W-1:0] rd_data;
  match_t match;
  learn_t status;
  logic   egress_port;
  logic   dest_found;
  learn_t learn_status;

  assign frame.ready = (state == S_IDLE) && !rst;
  assign fwd.valid = (state == S_DONE);
  assign fwd.egress_port = egress_port;
  assign fwd.dest_found = dest_found;
  assign fwd.learn_status = learn_status;

  assign rd_en = (state == S_SCAN) && (scan_addr < used_entries);

  always_comb begin
    if (match.src_hit) begin
      status = LEARN_UPDATED;
    end else if (used_entries < count_t'(TABLE_ENTRIES)) begin
      status = LEARN_NEW;
    end else begin
      status = LEARN_FULL;
    end
  end

  assign wr_en = (state == S_WRITE) && (status != LEARN_FULL);
  assign wr_addr = match.src_hit ? match.src_idx : used_entries[ADDR_W-1:0];

  mlft_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(TABLE_ENTRIES)
  ) u_ram (
    .clk  (clk),
    .we   (wr_en),
    .waddr(wr_addr),
    .wdata({src, port}),
    .re   (rd_en),
    .raddr(scan_addr[ADDR_W-1:0]),
    .rdata(rd_data)
  );

  mlft_match u_match (
    .clk    (clk),
    .clear  (frame.valid && frame.ready),
    .valid  (pend),
    .idx    (pend_idx),
    .entry  (rd_data),
    .src_mac(src),
    .dst_mac(dst),
    .match  (match)
  );

  always_ff @(posedge clk) begin
    if (frame.valid && frame.ready) begin
      port <= frame.ingress_port;
      src <= frame.source_mac;
      dst <= frame.dest_mac;
    end
    pend_idx <= scan_addr[ADDR_W-1:0];
    if (state == S_WRITE) begin
      learn_status <= status;
      if ((dst == src) && (status != LEARN_FULL)) begin
        dest_found <= 1'b1;
        egress_port <= port;
      end else begin
        dest_found <= match.dst_hit;
        egress_port <= match.dst_hit ? match.dst_port : ~port;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      used_entries <= '0;
      scan_addr <= '0;
      pend <= 1'b0;
    end else begin
      pend <= rd_en;
      unique case (state)
        S_IDLE: begin
          scan_addr <= '0;
          if (frame.valid) begin
            state <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (rd_en) begin
            scan_addr <= scan_addr + count_t'(1);
          end else begin
            state <= S_WRITE;
          end
        end
        S_WRITE: begin
          if (status == LEARN_NEW) begin
            used_entries <= used_entries + count_t'(1);
          end
          state <= S_DONE;
        end
        S_DONE: begin
          if (fwd.ready) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

### verif/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import mlft_pkg::*;

  localparam int LONG_GAP = 40;
  localparam int IDLE_LIMIT = 8 * (TABLE_ENTRIES + 4 + 2 * LONG_GAP);
  localparam int RANDOM_FRAMES = 532;
  localparam int FULL_FRAMES = 30;
  localparam mac_t BROADCAST = 48'hFFFF_FFFF_FFFF;
  localparam mac_t MULTICAST = 48'h0100_5E00_0001;

  typedef struct {
    logic ingress_port;
    mac_t source_mac;
    mac_t dest_mac;
  } frame_t;

  typedef struct {
    frame_t frm;
    int     gap;
  } pending_frame_t;

  typedef struct {
    logic   egress_port;
    logic   dest_found;
    learn_t learn_status;
  } forward_t;

  logic clk;
  logic rst;

  mlft_in_if  frame_if ();
  mlft_out_if fwd_if ();

  mac_learning_forward_table uut (
    .clk   (clk),
    .rst   (rst),
    .frame (frame_if),
    .fwd   (fwd_if)
  );

  // predicted station table
  mac_t station_mac [TABLE_ENTRIES];
  logic station_port [TABLE_ENTRIES];
  int   station_count;

  pending_frame_t frame_queue[$];
  forward_t       expected_fwd[$];

  // addresses that the generator has queued as learnable sources
  mac_t known_macs[$];
  bit   seen_mac [mac_t];

  bit in_fire;
  bit out_fire;
  int gap_done;
  int stall_left;
  int results_seen;
  int idle_cycles;
  int mismatches;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, LONG_GAP);
  endfunction

  function automatic int find_station(mac_t mac);
    for (int i = 0; i < station_count; i++) begin
      if (station_mac[i] == mac) return i;
    end
    return -1;
  endfunction

  function automatic forward_t learn_and_forward(frame_t f);
    forward_t r;
    int idx;
    idx = find_station(f.source_mac);
    if (idx >= 0) begin
      station_port[idx] = f.ingress_port;
      r.learn_status = LEARN_UPDATED;
    end else if (station_count < TABLE_ENTRIES) begin
      station_mac[station_count] = f.source_mac;
      station_port[station_count] = f.ingress_port;
      station_count++;
      r.learn_status = LEARN_NEW;
    end else begin
      r.learn_status = LEARN_FULL;
    end
    idx = find_station(f.dest_mac);
    if (idx >= 0) begin
      r.egress_port = station_port[idx];
      r.dest_found = 1'b1;
    end else begin
      r.egress_port = ~f.ingress_port;
      r.dest_found = 1'b0;
    end
    return r;
  endfunction

  function automatic mac_t fresh_mac();
    mac_t m;
    do begin
      m = mac_t'({$urandom(), $urandom()});
    end while (seen_mac.exists(m));
    return m;
  endfunction

  function automatic mac_t any_known_mac();
    return known_macs[$urandom_range(0, known_macs.size() - 1)];
  endfunction

  function automatic mac_t pick_dest(mac_t src);
    int r;
    r = $urandom_range(0, 99);
    if (r < 40 && known_macs.size() > 0) return any_known_mac();
    if (r < 55) return src;
    if (r < 60) return BROADCAST;
    if (r < 63) return '0;
    return mac_t'({$urandom(), $urandom()});
  endfunction

  task automatic queue_frame(logic port, mac_t src, mac_t dst, int gap);
    pending_frame_t p;
    p.frm.ingress_port = port;
    p.frm.source_mac = src;
    p.frm.dest_mac = dst;
    p.gap = gap;
    frame_queue.push_back(p);
    if (!seen_mac.exists(src) && known_macs.size() < TABLE_ENTRIES) begin
      seen_mac[src] = 1'b1;
      known_macs.push_back(src);
    end
  endtask

  // input driver
  always @(negedge clk) begin : drive_frames
    pending_frame_t nxt;
    if (rst) begin
      frame_if.valid <= 1'b0;
      gap_done <= 0;
    end else if (!(frame_if.valid && !in_fire)) begin
      if (frame_queue.size() == 0) begin
        frame_if.valid <= 1'b0;
      end else if (gap_done < frame_queue[0].gap) begin
        frame_if.valid <= 1'b0;
        gap_done <= gap_done + 1;
      end else begin
        nxt = frame_queue.pop_front();
        frame_if.valid <= 1'b1;
        frame_if.ingress_port <= nxt.frm.ingress_port;
        frame_if.source_mac <= nxt.frm.source_mac;
        frame_if.dest_mac <= nxt.frm.dest_mac;
        gap_done <= 0;
      end
    end
  end

  // result back-pressure, with a stretch of no stalls
  always @(negedge clk) begin : drive_ready
    int g;
    if (rst) begin
      fwd_if.ready <= 1'b0;
      stall_left <= 0;
    end else if (stall_left > 0) begin
      fwd_if.ready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if ((results_seen < 200 || results_seen >= 300) &&
                 (out_fire || $urandom_range(0, 15) == 0)) begin
      g = pick_gap();
      if (g > 0) begin
        fwd_if.ready <= 1'b0;
        stall_left <= g - 1;
      end else begin
        fwd_if.ready <= 1'b1;
      end
    end else begin
      fwd_if.ready <= 1'b1;
    end
  end

  // monitor, predictor and checker
  always @(posedge clk) begin : watch_ports
    frame_t f;
    forward_t exp;
    in_fire <= !rst && frame_if.valid && frame_if.ready;
    out_fire <= !rst && fwd_if.valid && fwd_if.ready;
    if (!rst && frame_if.valid && frame_if.ready) begin
      f.ingress_port = frame_if.ingress_port;
      f.source_mac = frame_if.source_mac;
      f.dest_mac = frame_if.dest_mac;
      expected_fwd.push_back(learn_and_forward(f));
    end
    if (!rst && fwd_if.valid && fwd_if.ready) begin
      results_seen <= results_seen + 1;
      if (expected_fwd.size() == 0) begin
        $display("%0t: unexpected item egress_port=%0d dest_found=%0d learn_status=%0d",
                 $time, fwd_if.egress_port, fwd_if.dest_found, fwd_if.learn_status);
        mismatches <= mismatches + 1;
      end else begin
        exp = expected_fwd.pop_front();
        if (fwd_if.egress_port !== exp.egress_port ||
            fwd_if.dest_found !== exp.dest_found ||
            fwd_if.learn_status !== exp.learn_status) begin
          $display("%0t: mismatch expected egress_port=%0d dest_found=%0d learn_status=%0d",
                   $time, exp.egress_port, exp.dest_found, exp.learn_status);
          $display("%0t:          actual   egress_port=%0d dest_found=%0d learn_status=%0d",
                   $time, fwd_if.egress_port, fwd_if.dest_found, fwd_if.learn_status);
          mismatches <= mismatches + 1;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((frame_if.valid && frame_if.ready) || (fwd_if.valid && fwd_if.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles + 1 >= IDLE_LIMIT) begin
      $display("mac_learning_forward_table regression: fail");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    mac_t src;
    mac_t dst;
    int r;
    rst = 1'b1;
    frame_if.valid = 1'b0;
    frame_if.ingress_port = 1'b0;
    frame_if.source_mac = '0;
    frame_if.dest_mac = '0;
    fwd_if.ready = 1'b0;
    station_count = 0;
    results_seen = 0;
    idle_cycles = 0;
    mismatches = 0;

    // directed frames on an empty table
    queue_frame(1'b0, '0, '0, 0);
    queue_frame(1'b1, BROADCAST, '0, 0);
    queue_frame(1'b0, MULTICAST, BROADCAST, 1);
    queue_frame(1'b1, '0, MULTICAST, 0);
    queue_frame(1'b0, MULTICAST, 48'h1234_5678_9ABC, 2);
    queue_frame(1'b1, 48'h0000_0000_0001, 48'h8000_0000_0000, 0);
    queue_frame(1'b1, 48'hAAAA_AAAA_AAAA, 48'h5555_5555_5555, 0);
    queue_frame(1'b0, 48'h5555_5555_5555, 48'hAAAA_AAAA_AAAA, 0);
    queue_frame(1'b1, 48'hAAAA_AAAA_AAAA, 48'h5555_5555_5555, 3);
    queue_frame(1'b0, BROADCAST, BROADCAST, 0);
    queue_frame(1'b0, 48'h8000_0000_0000, 48'h0000_0000_0001, 0);
    queue_frame(1'b1, 48'h0000_0000_0001, 48'h0000_0000_0001, 0);
    queue_frame(1'b1, 48'hFFFF_FFFF_FFFE, 48'hFFFF_FFFF_FFFE, 0);
    queue_frame(1'b0, 48'h7FFF_FFFF_FFFF, '0, 12);
    queue_frame(1'b1, 48'h0180_C200_0000, 48'h7FFF_FFFF_FFFF, 0);
    queue_frame(1'b0, 48'h0180_C200_0000, 48'h0180_C200_0000, 0);

    // random traffic over a growing station population
    for (int i = 0; i < RANDOM_FRAMES; i++) begin
      r = $urandom_range(0, 99);
      if (r < 55) src = any_known_mac();
      else src = fresh_mac();
      dst = pick_dest(src);
      queue_frame(1'($urandom_range(0, 1)), src, dst,
                  (i >= 200 && i < 280) ? 0 : pick_gap());
    end

    // late traffic: unseen sources mixed with known ones
    queue_frame(1'b0, 48'hDEAD_BEEF_0001, 48'hDEAD_BEEF_0001, 0);
    queue_frame(1'b1, 48'hDEAD_BEEF_0002, '0, 0);
    for (int i = 0; i < FULL_FRAMES; i++) begin
      r = $urandom_range(0, 99);
      if (r < 40) begin
        src = mac_t'({$urandom(), $urandom()});
        dst = (r < 15) ? src : pick_dest(src);
      end else begin
        src = any_known_mac();
        dst = pick_dest(src);
      end
      queue_frame(1'($urandom_range(0, 1)), src, dst, pick_gap());
    end

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    do @(posedge clk);
    while (frame_queue.size() != 0 || frame_if.valid || expected_fwd.size() != 0);
    repeat (TABLE_ENTRIES + 8) @(posedge clk);

    if (mismatches == 0 && expected_fwd.size() == 0) begin
      $display("mac_learning_forward_table regression: pass");
    end else begin
      $display("mac_learning_forward_table regression: fail");
    end
    $finish;
  end

endmodule
